>>> sv/hdr2bgra_pkg.sv
// Package: shared types, constants and the gamma table generator.
package hdr2bgra_pkg;

    localparam int COUNT_W         = 20;
    localparam int LEVEL_W         = 9;
    localparam int CHAN_W          = 16;
    localparam int BYTE_W          = 8;
    localparam int CFG_INDEX_W     = 2;
    localparam int GAMMA_W         = 16;
    localparam int PROD_W          = GAMMA_W + LEVEL_W;
    // Big integer width for the exact table search: 2^(176 + 5*16) needs 257 bits.
    localparam int BIG_W           = 264;
    localparam int GAMMA_RHS_SHIFT = 176;

    localparam int DEF_MAX_FRAME_PIXELS = 1048576;
    localparam int DEF_GAMMA_TABLE_BITS = 10;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [LEVEL_W-1:0] ALPHA_ONE = 9'd256;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_OPAQUE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OPAQUE_LEVEL = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLEAR_LEVEL  = 2'd2;

    localparam logic [COUNT_W-1:0] MIN_OPAQUE_RESET   = 20'd100;
    localparam logic [LEVEL_W-1:0] OPAQUE_LEVEL_RESET = 9'd230;
    localparam logic [LEVEL_W-1:0] CLEAR_LEVEL_RESET  = 9'd3;

    typedef struct packed {
        logic signed [CHAN_W-1:0] red_in;
        logic signed [CHAN_W-1:0] green_in;
        logic signed [CHAN_W-1:0] blue_in;
        logic signed [CHAN_W-1:0] inverse_opacity;
        logic                     last_pixel;
    } pixel_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  blue_out;
        logic [BYTE_W-1:0]  green_out;
        logic [BYTE_W-1:0]  red_out;
        logic [BYTE_W-1:0]  alpha_out;
        logic               frame_done;
        logic [COUNT_W-1:0] opaque_total;
        logic [COUNT_W-1:0] clear_total;
        logic               show_now;
    } result_t;

    typedef struct packed {
        logic [COUNT_W-1:0] min_opaque_count;
        logic [LEVEL_W-1:0] opaque_level;
        logic [LEVEL_W-1:0] clear_level;
    } cfg_t;

    typedef struct packed {
        logic               frame_done;
        logic [COUNT_W-1:0] opaque_total;
        logic [COUNT_W-1:0] clear_total;
        logic               show_now;
    } report_t;

    typedef struct packed {
        logic start;
        logic step;
    } lane_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_LOOKUP,
        ST_SCALE,
        ST_FINISH
    } state_t;

    // Largest g with g^11 * 2^(5*bits) <= idx^5 * 2^176, i.e. floor(65536 * x^(1/2.2)).
    function automatic logic [GAMMA_W-1:0] gamma_entry(input int unsigned idx,
                                                       input int unsigned bits);
        logic [BIG_W-1:0] rhs;
        logic [BIG_W-1:0] lhs;
        logic [GAMMA_W:0] lo;
        logic [GAMMA_W:0] hi;
        logic [GAMMA_W:0] mid;
        rhs = BIG_W'(1);
        for (int k = 0; k < 5; k++)
        begin
            rhs = rhs * BIG_W'(idx);
        end
        rhs = rhs << GAMMA_RHS_SHIFT;
        lo  = '0;
        hi  = (GAMMA_W+1)'(16'hFFFF);
        for (int s = 0; s <= GAMMA_W; s++)
        begin
            if (lo < hi)
            begin
                mid = lo + ((hi - lo + (GAMMA_W+1)'(1)) >> 1);
                lhs = BIG_W'(1);
                for (int k = 0; k < 11; k++)
                begin
                    lhs = lhs * BIG_W'(mid);
                end
                lhs = lhs << (5 * bits);
                if (lhs <= rhs)
                begin
                    lo = mid;
                end
                else
                begin
                    hi = mid - (GAMMA_W+1)'(1);
                end
            end
        end
        return lo[GAMMA_W-1:0];
    endfunction

endpackage

>>> sv/hdr2bgra_stream_if.sv
// Valid/ready stream interface carrying one payload per beat.
interface hdr2bgra_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/hdr2bgra_div.sv
// Bit-serial restoring divider: quot = floor(v * 2^BITS / (af + v)).
module hdr2bgra_div
    import hdr2bgra_pkg::*;
#(
    parameter int GAMMA_TABLE_BITS = DEF_GAMMA_TABLE_BITS
)
(
    input  logic                        clk,
    input  lane_ctl_t                   ctl,
    input  logic [CHAN_W-2:0]           v,
    input  logic [LEVEL_W-1:0]          af,
    output logic [GAMMA_TABLE_BITS-1:0] quot
);

    logic [CHAN_W-1:0]           rem_reg;
    logic [CHAN_W-1:0]           rem_next;
    logic [CHAN_W-1:0]           den_reg;
    logic [CHAN_W-1:0]           den_next;
    logic [GAMMA_TABLE_BITS-1:0] quot_reg;
    logic [GAMMA_TABLE_BITS-1:0] quot_next;
    logic [CHAN_W:0]             shifted;
    logic                        fits;

    always_comb
    begin
        shifted   = {rem_reg, 1'b0};
        fits      = shifted >= {1'b0, den_reg};
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        if (ctl.start)
        begin
            // remainder starts at v, which is always below af + v
            rem_next  = {1'b0, v};
            den_next  = CHAN_W'(v) + CHAN_W'(af);
            quot_next = '0;
        end
        else if (ctl.step)
        begin
            if (fits)
            begin
                rem_next = CHAN_W'(shifted - {1'b0, den_reg});
            end
            else
            begin
                rem_next = shifted[CHAN_W-1:0];
            end
            quot_next = {quot_reg[GAMMA_TABLE_BITS-2:0], fits};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign quot = quot_reg;

endmodule

>>> sv/hdr2bgra_gamma_rom.sv
// Gamma 1/2.2 table, Q0.16 entries, registered read.
module hdr2bgra_gamma_rom
    import hdr2bgra_pkg::*;
#(
    parameter int GAMMA_TABLE_BITS = DEF_GAMMA_TABLE_BITS
)
(
    input  logic                        clk,
    input  logic [GAMMA_TABLE_BITS-1:0] addr,
    output logic [GAMMA_W-1:0]          data
);

    localparam int SIZE = 1 << GAMMA_TABLE_BITS;

    logic [GAMMA_W-1:0] rom [SIZE];
    logic [GAMMA_W-1:0] data_reg;

    for (genvar k = 0; k < SIZE; k++)
    begin : g_entry
        localparam logic [GAMMA_W-1:0] VALUE = gamma_entry(k, GAMMA_TABLE_BITS);
        assign rom[k] = VALUE;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= rom[addr];
    end

    assign data = data_reg;

endmodule

>>> sv/hdr2bgra_lane.sv
// One color lane: divide, gamma lookup, alpha re-premultiply, byte out.
module hdr2bgra_lane
    import hdr2bgra_pkg::*;
#(
    parameter int GAMMA_TABLE_BITS = DEF_GAMMA_TABLE_BITS
)
(
    input  logic                     clk,
    input  lane_ctl_t                ctl,
    input  logic signed [CHAN_W-1:0] channel,
    input  logic [LEVEL_W-1:0]       af,
    input  logic [LEVEL_W-1:0]       alpha,
    output logic [BYTE_W-1:0]        byte_out
);

    logic [CHAN_W-2:0]           v;
    logic [GAMMA_TABLE_BITS-1:0] quot;
    logic [GAMMA_W-1:0]          gamma;
    logic [PROD_W-1:0]           prod_reg;
    logic [PROD_W+BYTE_W-1:0]    scaled;
    logic [BYTE_W:0]             byte_full;

    // negative HDR values clamp to zero
    assign v = channel[CHAN_W-1] ? '0 : channel[CHAN_W-2:0];

    hdr2bgra_div #(
        .GAMMA_TABLE_BITS (GAMMA_TABLE_BITS)
    ) u_div (
        .clk  (clk),
        .ctl  (ctl),
        .v    (v),
        .af   (af),
        .quot (quot)
    );

    hdr2bgra_gamma_rom #(
        .GAMMA_TABLE_BITS (GAMMA_TABLE_BITS)
    ) u_rom (
        .clk  (clk),
        .addr (quot),
        .data (gamma)
    );

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(gamma) * PROD_W'(alpha);
    end

    // prod * 255 / 2^24
    always_comb
    begin
        scaled    = {prod_reg, {BYTE_W{1'b0}}} - (PROD_W+BYTE_W)'(prod_reg);
        byte_full = scaled[PROD_W+BYTE_W-1:24];
        byte_out  = byte_full[BYTE_W] ? {BYTE_W{1'b1}} : byte_full[BYTE_W-1:0];
    end

endmodule

>>> sv/hdr2bgra_stats.sv
// Frame coverage counters and end-of-frame report.
module hdr2bgra_stats
    import hdr2bgra_pkg::*;
#(
    parameter int MAX_FRAME_PIXELS = DEF_MAX_FRAME_PIXELS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic               last,
    input  logic [LEVEL_W-1:0] alpha,
    input  cfg_t               cfg,
    output report_t            report
);

    localparam int PIX_W = $clog2(MAX_FRAME_PIXELS + 1);
    localparam int CMP_W = (PIX_W > COUNT_W) ? PIX_W : COUNT_W;
    localparam logic [PIX_W-1:0] PIX_MAX = PIX_W'(MAX_FRAME_PIXELS);

    logic [COUNT_W-1:0] opaque_cnt_reg;
    logic [COUNT_W-1:0] opaque_cnt_next;
    logic [COUNT_W-1:0] clear_cnt_reg;
    logic [COUNT_W-1:0] clear_cnt_next;
    logic [PIX_W-1:0]   pix_cnt_reg;
    logic [PIX_W-1:0]   pix_cnt_next;
    logic               presented_reg;
    logic               presented_next;
    report_t            report_reg;
    report_t            report_next;

    logic               opaque_inc;
    logic               clear_inc;
    logic [COUNT_W-1:0] opaque_new;
    logic [COUNT_W-1:0] clear_new;
    logic [PIX_W-1:0]   pix_new;
    logic               show;

    always_comb
    begin
        opaque_inc = (alpha > cfg.opaque_level) && (opaque_cnt_reg != COUNT_MAX);
        clear_inc  = (alpha < cfg.clear_level) && (clear_cnt_reg != COUNT_MAX);
        opaque_new = opaque_cnt_reg + COUNT_W'(opaque_inc);
        clear_new  = clear_cnt_reg + COUNT_W'(clear_inc);
        pix_new    = pix_cnt_reg + PIX_W'(pix_cnt_reg < PIX_MAX);
        show       = !presented_reg && (opaque_new > cfg.min_opaque_count)
                     && (CMP_W'(clear_new) > CMP_W'(pix_new >> 1));

        opaque_cnt_next = opaque_cnt_reg;
        clear_cnt_next  = clear_cnt_reg;
        pix_cnt_next    = pix_cnt_reg;
        presented_next  = presented_reg;
        report_next     = report_reg;
        if (accept)
        begin
            report_next = '0;
            if (last)
            begin
                report_next.frame_done   = 1'b1;
                report_next.opaque_total = opaque_new;
                report_next.clear_total  = clear_new;
                report_next.show_now     = show;
                presented_next           = presented_reg | show;
                opaque_cnt_next          = '0;
                clear_cnt_next           = '0;
                pix_cnt_next             = '0;
            end
            else
            begin
                opaque_cnt_next = opaque_new;
                clear_cnt_next  = clear_new;
                pix_cnt_next    = pix_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opaque_cnt_reg <= '0;
            clear_cnt_reg  <= '0;
            pix_cnt_reg    <= '0;
            presented_reg  <= 1'b0;
            report_reg     <= '0;
        end
        else
        begin
            opaque_cnt_reg <= opaque_cnt_next;
            clear_cnt_reg  <= clear_cnt_next;
            pix_cnt_reg    <= pix_cnt_next;
            presented_reg  <= presented_next;
            report_reg     <= report_next;
        end
    end

    assign report = report_reg;

endmodule

>>> sv/hdr_to_premultiplied_bgra.sv
// Top level: HDR Q8.8 pixels in, premultiplied gamma-mapped BGRA bytes and frame stats out.
//
// Each accepted pixel beat has its alpha formed as clamp(1 - inverse_opacity, 0, 1) in
// Q8.8, and each of red, green and blue goes through its own lane: a Reinhard map
// v / (alpha + v) done by a bit-per-cycle divider, a gamma 1/2.2 lookup in a constant
// table of 2^GAMMA_TABLE_BITS entries, and a multiply back by alpha. The three lanes run
// side by side and their bytes merge with alpha and the frame report into one output
// register. One pixel is in flight at a time: after acceptance it goes through the divider,
// which produces one table-index bit per cycle, then the table read, the alpha multiply and
// the output load. The sequencer returns to idle once the result is registered and accepts
// the next pixel there, even if that result beat is still waiting downstream; a stalled
// output holds the following pixel in its last stage. Opaque and clear pixels are counted
// per frame; the beat of a frame's last pixel carries frame_done, both totals, and show_now
// on the first frame whose opaque count exceeds min_opaque_count and whose clear count
// exceeds half the frame. Counters saturate (20 bits for opaque/clear, MAX_FRAME_PIXELS
// for the pixel count). Configuration writes go straight into the registers and must only
// happen while idle.
module hdr_to_premultiplied_bgra
    import hdr2bgra_pkg::*;
#(
    parameter int MAX_FRAME_PIXELS = DEF_MAX_FRAME_PIXELS,
    parameter int GAMMA_TABLE_BITS = DEF_GAMMA_TABLE_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    hdr2bgra_stream_if.sink        pixel,
    hdr2bgra_stream_if.source      result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [COUNT_W-1:0]     cfg_data
);

    localparam int STEP_W = $clog2(GAMMA_TABLE_BITS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(GAMMA_TABLE_BITS - 1);

    state_t             state_reg;
    state_t             state_next;
    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  step_next;
    cfg_t               cfg_reg;
    logic [LEVEL_W-1:0] alpha_reg;
    logic [LEVEL_W-1:0] alpha_next;
    result_t            result_reg;
    result_t            result_next;
    logic               result_valid_reg;
    logic               result_valid_next;

    logic               accept;
    logic               load_result;
    lane_ctl_t          lane_ctl;
    logic signed [17:0] alpha_raw;
    logic [LEVEL_W-1:0] alpha_calc;
    logic [LEVEL_W-1:0] af;
    logic [BYTE_W-1:0]  red_byte;
    logic [BYTE_W-1:0]  green_byte;
    logic [BYTE_W-1:0]  blue_byte;
    logic [16:0]        alpha_scaled;
    report_t            report;

    // ---- alpha = clamp(256 - inverse_opacity, 0, 256), floored at one step for division
    always_comb
    begin
        alpha_raw = 18'sd256 - {{2{pixel.data.inverse_opacity[CHAN_W-1]}},
                                pixel.data.inverse_opacity};
        if (alpha_raw[17])
        begin
            alpha_calc = '0;
        end
        else if (alpha_raw > 18'sd256)
        begin
            alpha_calc = ALPHA_ONE;
        end
        else
        begin
            alpha_calc = alpha_raw[LEVEL_W-1:0];
        end
        af = (alpha_calc == '0) ? LEVEL_W'(1) : alpha_calc;
    end

    assign accept     = pixel.valid && pixel.ready;
    assign alpha_next = accept ? alpha_calc : alpha_reg;

    // ---- configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_opaque_count <= MIN_OPAQUE_RESET;
            cfg_reg.opaque_level     <= OPAQUE_LEVEL_RESET;
            cfg_reg.clear_level      <= CLEAR_LEVEL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MIN_OPAQUE:   cfg_reg.min_opaque_count <= cfg_data;
                CFG_OPAQUE_LEVEL: cfg_reg.opaque_level     <= cfg_data[LEVEL_W-1:0];
                CFG_CLEAR_LEVEL:  cfg_reg.clear_level      <= cfg_data[LEVEL_W-1:0];
                default:          ;
            endcase
        end
    end

    // ---- sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pixel.valid)
                begin
                    state_next = ST_DIVIDE;
                    step_next  = '0;
                end
            end
            ST_DIVIDE:
            begin
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_LOOKUP;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_LOOKUP: state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (!result_valid_reg || result.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // ---- sequencer: outputs
    always_comb
    begin
        pixel.ready    = 1'b0;
        lane_ctl.start = 1'b0;
        lane_ctl.step  = 1'b0;
        load_result    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                pixel.ready    = 1'b1;
                lane_ctl.start = pixel.valid;
            end
            ST_DIVIDE: lane_ctl.step = 1'b1;
            ST_FINISH: load_result = !result_valid_reg || result.ready;
            default:   ;
        endcase
    end

    // ---- lanes
    hdr2bgra_lane #(
        .GAMMA_TABLE_BITS (GAMMA_TABLE_BITS)
    ) u_lane_red (
        .clk      (clk),
        .ctl      (lane_ctl),
        .channel  (pixel.data.red_in),
        .af       (af),
        .alpha    (alpha_reg),
        .byte_out (red_byte)
    );

    hdr2bgra_lane #(
        .GAMMA_TABLE_BITS (GAMMA_TABLE_BITS)
    ) u_lane_green (
        .clk      (clk),
        .ctl      (lane_ctl),
        .channel  (pixel.data.green_in),
        .af       (af),
        .alpha    (alpha_reg),
        .byte_out (green_byte)
    );

    hdr2bgra_lane #(
        .GAMMA_TABLE_BITS (GAMMA_TABLE_BITS)
    ) u_lane_blue (
        .clk      (clk),
        .ctl      (lane_ctl),
        .channel  (pixel.data.blue_in),
        .af       (af),
        .alpha    (alpha_reg),
        .byte_out (blue_byte)
    );

    // ---- frame statistics, updated at acceptance
    hdr2bgra_stats #(
        .MAX_FRAME_PIXELS (MAX_FRAME_PIXELS)
    ) u_stats (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .last   (pixel.data.last_pixel),
        .alpha  (alpha_calc),
        .cfg    (cfg_reg),
        .report (report)
    );

    // ---- merge lanes, alpha byte and report into the output register
    always_comb
    begin
        alpha_scaled             = {alpha_reg, 8'd0} - 17'(alpha_reg);
        result_next              = result_reg;
        result_valid_next        = result_valid_reg;
        if (result.ready)
        begin
            result_valid_next = 1'b0;
        end
        if (load_result)
        begin
            result_next.blue_out     = blue_byte;
            result_next.green_out    = green_byte;
            result_next.red_out      = red_byte;
            result_next.alpha_out    = alpha_scaled[15:8];
            result_next.frame_done   = report.frame_done;
            result_next.opaque_total = report.opaque_total;
            result_next.clear_total  = report.clear_total;
            result_next.show_now     = report.show_now;
            result_valid_next        = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        alpha_reg  <= alpha_next;
        result_reg <= result_next;
    end

    assign result.valid = result_valid_reg;
    assign result.data  = result_reg;

    // ---- checks
    a_accept_starts_divide: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_DIVIDE) && (step_reg == '0))
        else $error("accepted pixel did not start the divider");

    a_divide_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) && (step_reg == STEP_LAST) |=> (state_reg == ST_LOOKUP))
        else $error("divider ran the wrong number of steps");

    a_load_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result loaded outside the finish state");

    a_report_only_on_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_reg.frame_done |->
            (result_reg.opaque_total == '0) && (result_reg.clear_total == '0)
            && !result_reg.show_now)
        else $error("frame report on a pixel that does not end a frame");

endmodule

>>> sim/tb.sv
// Self-checking testbench for hdr_to_premultiplied_bgra: directed pixels, random frames, scoreboard.
module tb;
    import hdr2bgra_pkg::*;

    localparam int LUT_BITS    = DEF_GAMMA_TABLE_BITS;
    localparam int LUT_SIZE    = 1 << LUT_BITS;
    localparam int WIDE_W      = 240;
    // g^11 vs x^5 with g in Q0.16 and x in Q0.LUT_BITS: both sides scaled by 2^(11*16 + 5*LUT_BITS)
    localparam int GAMMA_SHIFT = 11 * GAMMA_W;
    localparam int DRAIN_CYCLES = DEF_GAMMA_TABLE_BITS + 20;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int PHASE_ITEMS  = 165;

    // index past the last register, must be ignored by the block
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

    // Predicts one BGRA beat per accepted pixel and checks result beats in order.
    class bgra_scoreboard;
        logic [GAMMA_W-1:0] gamma_lut [0:LUT_SIZE-1];
        logic [COUNT_W-1:0] min_opaque;
        logic [LEVEL_W-1:0] opaque_lvl;
        logic [LEVEL_W-1:0] clear_lvl;
        int unsigned        opaque_cnt;
        int unsigned        clear_cnt;
        int unsigned        pixel_cnt;
        bit                 shown;
        result_t            expected_bgra [$];
        int                 errors;

        function new();
            build_gamma();
            min_opaque = MIN_OPAQUE_RESET;
            opaque_lvl = OPAQUE_LEVEL_RESET;
            clear_lvl  = CLEAR_LEVEL_RESET;
            opaque_cnt = 0;
            clear_cnt  = 0;
            pixel_cnt  = 0;
            shown      = 1'b0;
            errors     = 0;
        endfunction

        // exact test of (g/2^16)^11 <= (i/2^LUT_BITS)^5
        function bit gamma_fits(int unsigned g, int unsigned i);
            logic [WIDE_W-1:0] lhs;
            logic [WIDE_W-1:0] rhs;
            lhs = WIDE_W'(1);
            rhs = WIDE_W'(1);
            repeat (11) lhs = lhs * WIDE_W'(g);
            repeat (5) rhs = rhs * WIDE_W'(i);
            return (lhs << (5 * LUT_BITS)) <= (rhs << GAMMA_SHIFT);
        endfunction

        // start from the real-valued estimate, then settle on the exact largest fit
        function void build_gamma();
            for (int i = 0; i < LUT_SIZE; i++)
            begin
                real x;
                int  g;
                x = real'(i) / real'(LUT_SIZE);
                g = $rtoi(65536.0 * (x ** (1.0 / 2.2)));
                if (g > 65535)
                    g = 65535;
                if (g < 0)
                    g = 0;
                while (g < 65535 && gamma_fits(g + 1, i))
                    g++;
                while (g > 0 && !gamma_fits(g, i))
                    g--;
                gamma_lut[i] = g[GAMMA_W-1:0];
            end
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [COUNT_W-1:0] val);
            case (idx)
                CFG_MIN_OPAQUE:   min_opaque = val;
                CFG_OPAQUE_LEVEL: opaque_lvl = val[LEVEL_W-1:0];
                CFG_CLEAR_LEVEL:  clear_lvl  = val[LEVEL_W-1:0];
                default: ;
            endcase
        endfunction

        // Reinhard v/(af+v) as table index, gamma lookup, then back to premultiplied
        function logic [BYTE_W-1:0] map_channel(logic signed [CHAN_W-1:0] chan,
                                                int unsigned alpha);
            int              level;
            longint unsigned v;
            longint unsigned af;
            longint unsigned idx;
            longint unsigned g;
            longint unsigned prod;
            level = chan;
            v     = (level < 0) ? 64'd0 : 64'(level);
            af    = (alpha < 1) ? 64'd1 : 64'(alpha);
            idx   = (v << LUT_BITS) / (af + v);
            g     = 64'(gamma_lut[idx[LUT_BITS-1:0]]);
            prod  = (g * 64'(alpha) * 64'd255) >> 24;
            return (prod > 255) ? 8'd255 : prod[BYTE_W-1:0];
        endfunction

        function void predict_pixel(pixel_t p);
            int          inv;
            int          al;
            int unsigned alpha;
            bit          show;
            result_t     r;
            inv   = $signed(p.inverse_opacity);
            al    = 256 - inv;
            alpha = (al < 0) ? 0 : ((al > 256) ? 256 : al);

            if (alpha > opaque_lvl && opaque_cnt < COUNT_MAX)
                opaque_cnt++;
            if (alpha < clear_lvl && clear_cnt < COUNT_MAX)
                clear_cnt++;
            if (pixel_cnt < DEF_MAX_FRAME_PIXELS)
                pixel_cnt++;

            r           = '0;
            r.blue_out  = map_channel(p.blue_in, alpha);
            r.green_out = map_channel(p.green_in, alpha);
            r.red_out   = map_channel(p.red_in, alpha);
            r.alpha_out = BYTE_W'((alpha * 255) >> 8);

            if (p.last_pixel)
            begin
                show = !shown && opaque_cnt > min_opaque && clear_cnt > pixel_cnt / 2;
                r.frame_done   = 1'b1;
                r.opaque_total = opaque_cnt[COUNT_W-1:0];
                r.clear_total  = clear_cnt[COUNT_W-1:0];
                r.show_now     = show;
                if (show)
                    shown = 1'b1;
                opaque_cnt = 0;
                clear_cnt  = 0;
                pixel_cnt  = 0;
            end
            expected_bgra.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned e, int unsigned a);
            if (e != a)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, e, a);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_bgra.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat, expected none actual %h", $time, got);
                return;
            end
            want = expected_bgra.pop_front();
            compare_field("blue_out",     want.blue_out,     got.blue_out);
            compare_field("green_out",    want.green_out,    got.green_out);
            compare_field("red_out",      want.red_out,      got.red_out);
            compare_field("alpha_out",    want.alpha_out,    got.alpha_out);
            compare_field("frame_done",   want.frame_done,   got.frame_done);
            compare_field("opaque_total", want.opaque_total, got.opaque_total);
            compare_field("clear_total",  want.clear_total,  got.clear_total);
            compare_field("show_now",     want.show_now,     got.show_now);
        endfunction

        function int outstanding();
            return expected_bgra.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [COUNT_W-1:0]     cfg_data;

    hdr2bgra_stream_if #(.payload_t(pixel_t))  pix_if ();
    hdr2bgra_stream_if #(.payload_t(result_t)) res_if ();

    hdr_to_premultiplied_bgra dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pix_if),
        .result    (res_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bgra_scoreboard board;

    int burst_left;
    int stall_mode;
    int stall_left;
    int rx_tick;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Result side: check each beat, then pick next ready from the current stall mode.
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
            board.check_result(res_if.data);
        rx_tick <= rx_tick + 1;
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       res_if.ready <= 1'b1;
            1:       res_if.ready <= 1'($urandom_range(0, 1));
            2:       res_if.ready <= ($urandom_range(0, 7) == 0);
            default: res_if.ready <= ((rx_tick % 32) < 4);   // long stalls
        endcase
    end

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb: FAIL");
        $finish;
    end

    function automatic pixel_t make_pixel(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                                          logic [CHAN_W-1:0] b, logic [CHAN_W-1:0] inv,
                                          logic last);
        pixel_t p;
        p.red_in          = r;
        p.green_in        = g;
        p.blue_in         = b;
        p.inverse_opacity = inv;
        p.last_pixel      = last;
        return p;
    endfunction

    // channels: rails, negatives, small values, anything
    function automatic logic [CHAN_W-1:0] pick_channel();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'($urandom_range(1, 255));
            4:       return 16'h0000 - 16'($urandom_range(1, 300));
            5:       return 16'($urandom_range(256, 4096));
            default: return 16'($urandom);
        endcase
    endfunction

    // inverse opacity: mostly inside 0..1, with both clamps and the level edges
    function automatic logic [CHAN_W-1:0] pick_inverse();
        case ($urandom_range(0, 9))
            0:       return 16'($urandom);
            1:       return 16'h0000 - 16'($urandom_range(0, 1000));
            2:       return 16'($urandom_range(256, 2000));
            3:       return 16'($urandom_range(248, 256));
            4:       return 16'($urandom_range(0, 32));
            default: return 16'($urandom_range(0, 256));
        endcase
    endfunction

    // Hold valid until a beat is taken; valid is left high for a back-to-back follower.
    task automatic send_pixel(input pixel_t p);
        pix_if.valid <= 1'b1;
        pix_if.data  <= p;
        @(posedge clk);
        while (!pix_if.ready)
            @(posedge clk);
        board.predict_pixel(p);
    endtask

    // Bursts of random length, random gaps between them (gap 0 keeps the stream tight).
    task automatic paced_send(input pixel_t p);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                pix_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        send_pixel(p);
        burst_left--;
    endtask

    task automatic wait_idle();
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Back-to-back writes of all registers plus the unused index; block must be idle.
    task automatic program_regs(input logic [COUNT_W-1:0] min_val,
                                input logic [COUNT_W-1:0] op_val,
                                input logic [COUNT_W-1:0] cl_val);
        logic [CFG_INDEX_W-1:0] idx [4];
        logic [COUNT_W-1:0]     val [4];
        idx[0] = CFG_MIN_OPAQUE;   val[0] = min_val;
        idx[1] = CFG_OPAQUE_LEVEL; val[1] = op_val;
        idx[2] = CFG_CLEAR_LEVEL;  val[2] = cl_val;
        idx[3] = CFG_SPARE;        val[3] = COUNT_W'($urandom);
        for (int k = 0; k < 4; k++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            board.set_reg(idx[k], val[k]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Random frames, mostly short; a stray last_pixel now and then breaks a frame early.
    task automatic random_phase(input int count);
        int     left;
        int     len;
        pixel_t p;
        left = count;
        while (left > 0)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 12);
            if (len > left)
                len = left;
            for (int k = 0; k < len; k++)
            begin
                p = make_pixel(pick_channel(), pick_channel(), pick_channel(), pick_inverse(),
                               (k == len - 1) || ($urandom_range(0, 63) == 0));
                paced_send(p);
            end
            left -= len;
        end
        pix_if.valid <= 1'b0;
        wait_idle();
    endtask

    initial
    begin : main
        pix_if.valid = 1'b0;
        pix_if.data  = '0;
        res_if.ready = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_MIN_OPAQUE;
        cfg_data     = '0;
        burst_left   = 0;
        stall_mode   = 0;
        stall_left   = 0;
        rx_tick      = 0;
        board        = new();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset register values (opaque above 230, clear below 3)
        paced_send(make_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0));
        paced_send(make_pixel(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, 1'b0));
        paced_send(make_pixel(16'h8000, 16'h8000, 16'h8000, 16'h0000, 1'b0)); // negative -> 0
        paced_send(make_pixel(16'h7FFF, 16'h0100, 16'h0001, 16'h0100, 1'b0)); // zero alpha
        paced_send(make_pixel(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 1'b0)); // alpha clamps to 1
        paced_send(make_pixel(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0)); // alpha clamps to 0
        paced_send(make_pixel(16'h0001, 16'h7FFF, 16'h0100, 16'h00FF, 1'b0)); // alpha 1
        paced_send(make_pixel(16'h0080, 16'h0040, 16'h0200, 16'h0080, 1'b0));
        paced_send(make_pixel(16'h012C, 16'h012C, 16'h012C, 16'h001A, 1'b0)); // alpha 230
        paced_send(make_pixel(16'h012C, 16'h012C, 16'h012C, 16'h0019, 1'b0)); // alpha 231
        paced_send(make_pixel(16'h012C, 16'h012C, 16'h012C, 16'h00FD, 1'b0)); // alpha 3
        paced_send(make_pixel(16'h012C, 16'h012C, 16'h012C, 16'h00FE, 1'b0)); // alpha 2
        paced_send(make_pixel(16'hFFFF, 16'h0001, 16'h7FFF, 16'hFFFF, 1'b1)); // frame end
        paced_send(make_pixel(16'h0032, 16'h003C, 16'h0046, 16'h0000, 1'b1)); // one-pixel frame
        pix_if.valid <= 1'b0;
        wait_idle();

        // Any mid alpha is both opaque and clear here, so a one-pixel frame shows
        program_regs(20'd0, 20'd0, 20'd256);
        paced_send(make_pixel(16'h00C8, 16'h0064, 16'h0032, 16'h0080, 1'b1));
        paced_send(make_pixel(16'h00C8, 16'h0064, 16'h0032, 16'h0080, 1'b1)); // already shown
        paced_send(make_pixel(16'h1000, 16'h0000, 16'h0800, 16'h0000, 1'b1));
        paced_send(make_pixel(16'h1000, 16'h0000, 16'h0800, 16'h0100, 1'b1));
        pix_if.valid <= 1'b0;
        wait_idle();

        // Random phases over register extremes and mixed settings
        random_phase(PHASE_ITEMS);
        program_regs(20'hFFFFF, 20'd256, 20'd0);
        random_phase(PHASE_ITEMS);
        program_regs(20'd0, 20'd0, 20'd0);
        random_phase(PHASE_ITEMS);
        program_regs(20'd5, 20'd128, 20'd129);
        random_phase(PHASE_ITEMS);
        program_regs(20'h00010, 20'hFFF00, 20'h001FF);    // upper bits masked off
        random_phase(PHASE_ITEMS);
        program_regs(COUNT_W'($urandom_range(0, 30)), COUNT_W'($urandom_range(0, 256)),
                     COUNT_W'($urandom_range(0, 256)));
        random_phase(PHASE_ITEMS);
        program_regs(COUNT_W'($urandom), COUNT_W'($urandom_range(0, 511)),
                     COUNT_W'($urandom_range(0, 511)));
        random_phase(PHASE_ITEMS);
        program_regs(MIN_OPAQUE_RESET, OPAQUE_LEVEL_RESET, CLEAR_LEVEL_RESET);
        random_phase(PHASE_ITEMS);

        if (board.errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
